// File: rtl/xymq_pkg.sv
package xymq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int POS_W    = 16;
    localparam int MAXSP_W  = 16;
    localparam int SPEED_W  = 24;
    localparam int SPEED_FRAC = SPEED_W - MAXSP_W;
    localparam int TIME_W   = 32;
    localparam int TOTAL_W  = 36;
    localparam int QLEN_W   = 5;

    localparam int DIV_DW = POS_W + SPEED_W;
    localparam int DIV_VW = SPEED_W;
    localparam int DIV_CW = $clog2(DIV_DW);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 160;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SPEED_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SPEED_Y = 1'b1;

    localparam logic [MAXSP_W-1:0] MAX_SPEED_RESET = 16'd1000;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_SERVICE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/xy_move_queue_planner.sv
// Two-axis move queue planner. An enqueue request plans per-axis speeds from the last
// stored stop so that both axes finish together, stores the move and returns speeds,
// move time, queued total and queue length; a service request pops the front move
// to an idle controller. All planning math runs through one 40-step restoring divider
// (one quotient bit per cycle), used up to four times per move: never for a service
// request or a zero-length move, once for a move along one axis and up to four times
// for a move along both axes. The block takes no new request while an item is in
// work. One finished result can wait in the output register while the next request
// is worked on; the next result then holds the block until the waiting one is taken.
module xy_move_queue_planner #(
    parameter int QUEUE_DEPTH = xymq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_x, target_y, dwell_time, controller_idle
    input  logic [xymq_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // x_speed, y_speed, move_time, total_time, queue_length, dispatch_valid,
    // dispatch_x, dispatch_y, queue_full_drop
    output logic [xymq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [xymq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [xymq_pkg::MAXSP_W-1:0]        cfg_wdata
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W = xymq_pkg::POS_W;
    localparam int SPD_W = xymq_pkg::SPEED_W;
    localparam int TM_W  = xymq_pkg::TIME_W;
    localparam int TOT_W = xymq_pkg::TOTAL_W;
    localparam int DW    = xymq_pkg::DIV_DW;
    localparam int ENT_W = 2 * POS_W + TM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PLAN, S_VX_DIV, S_VX_WAIT, S_VY_MUL, S_VY_DIV, S_VY_WAIT,
        S_TX_DIV, S_TX_WAIT, S_TY_DIV, S_TY_WAIT, S_COMMIT, S_SVC, S_OUT
    } state_t;

    state_t                      state_reg;
    logic                        out_valid_reg;
    logic [xymq_pkg::MAXSP_W-1:0] max_x_reg;
    logic [xymq_pkg::MAXSP_W-1:0] max_y_reg;
    logic [IDX_W-1:0]            head_reg;
    logic [IDX_W-1:0]            tail_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [POS_W-1:0]            last_x_reg;
    logic [POS_W-1:0]            last_y_reg;

    logic [POS_W-1:0]            tgt_x_reg;
    logic [POS_W-1:0]            tgt_y_reg;
    logic [TM_W-1:0]             dwell_reg;
    logic                        idle_reg;
    logic [POS_W-1:0]            dx_reg;
    logic [POS_W-1:0]            dy_reg;
    logic [DW-1:0]               prod_reg;
    logic [SPD_W-1:0]            vx_reg;
    logic [SPD_W-1:0]            vy_reg;
    logic [TM_W-1:0]             tx_t_reg;
    logic [TM_W-1:0]             ty_t_reg;

    logic [SPD_W-1:0]            res_xs_reg;
    logic [SPD_W-1:0]            res_ys_reg;
    logic [TM_W-1:0]             res_mt_reg;
    logic                        res_dv_reg;
    logic [POS_W-1:0]            res_dx_reg;
    logic [POS_W-1:0]            res_dy_reg;
    logic                        res_drop_reg;
    logic [xymq_pkg::M_TDATA_W-1:0] out_data_reg;

    logic [ENT_W-1:0]            mem [QUEUE_DEPTH];
    logic [ENT_W-1:0]            rd_data_reg;

    logic [POS_W-1:0]            in_x;
    logic [POS_W-1:0]            in_y;
    logic [TM_W-1:0]             in_dwell;
    logic                        in_idle;
    logic                        accept;
    logic [SPD_W-1:0]            mx;
    logic [SPD_W-1:0]            my;
    logic                        zero_move;
    logic                        queue_full;
    logic                        dispatch;
    logic                        out_free;
    logic [POS_W-1:0]            mul_a;
    logic [SPD_W-1:0]            mul_b;
    logic [DW-1:0]               mul_p;
    logic                        div_start;
    logic [DW-1:0]               div_dividend;
    logic [xymq_pkg::DIV_VW-1:0] div_divisor;
    xymq_pkg::div_stat_t         div_stat;
    logic [DW-1:0]               div_q;
    logic [SPD_W-1:0]            q_sat24;
    logic [TM_W-1:0]             q_sat32;
    logic [TM_W-1:0]             plan_time;
    logic [TM_W-1:0]             rd_t;
    logic [POS_W-1:0]            rd_x;
    logic [POS_W-1:0]            rd_y;
    logic [IDX_W-1:0]            tail_inc;
    logic [IDX_W-1:0]            head_inc;
    logic [xymq_pkg::M_TDATA_W-1:0] out_pack;

    assign in_x     = s_axis_tdata[POS_W-1:0];
    assign in_y     = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_dwell = s_axis_tdata[2*POS_W+TM_W-1:2*POS_W];
    assign in_idle  = s_axis_tdata[2*POS_W+TM_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign mx = {max_x_reg, xymq_pkg::SPEED_FRAC'(0)};
    assign my = {max_y_reg, xymq_pkg::SPEED_FRAC'(0)};

    assign zero_move  = (dx_reg == '0) && (dy_reg == '0);
    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign dispatch   = (count_reg != '0) && idle_reg;

    assign rd_x = rd_data_reg[POS_W-1:0];
    assign rd_y = rd_data_reg[2*POS_W-1:POS_W];
    assign rd_t = rd_data_reg[ENT_W-1:2*POS_W];

    assign tail_inc = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // single shared multiplier
    assign mul_a = (state_reg == S_VY_MUL) ? dy_reg : dx_reg;
    assign mul_b = (state_reg == S_VY_MUL) ? mx : my;
    assign mul_p = DW'(mul_a) * DW'(mul_b);

    assign q_sat24 = (|div_q[DW-1:SPD_W]) ? '1 : div_q[SPD_W-1:0];
    assign q_sat32 = (|div_q[DW-1:TM_W]) ? '1 : div_q[TM_W-1:0];

    assign plan_time = zero_move ? dwell_reg :
                       ((tx_t_reg > ty_t_reg) ? tx_t_reg : ty_t_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_VX_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = xymq_pkg::DIV_VW'(dy_reg);
            end
            S_VY_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = xymq_pkg::DIV_VW'(dx_reg);
            end
            S_TX_DIV:
            begin
                div_start    = (dx_reg != '0) && (vx_reg != '0);
                div_dividend = {dx_reg, SPD_W'(0)};
                div_divisor  = vx_reg;
            end
            S_TY_DIV:
            begin
                div_start    = (dy_reg != '0) && (vy_reg != '0);
                div_dividend = {dy_reg, SPD_W'(0)};
                div_divisor  = vy_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    xymq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            max_x_reg     <= xymq_pkg::MAX_SPEED_RESET;
            max_y_reg     <= xymq_pkg::MAX_SPEED_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    xymq_pkg::CFG_MAX_SPEED_X:
                        max_x_reg <= (cfg_wdata == '0) ? xymq_pkg::MAXSP_W'(1) : cfg_wdata;
                    xymq_pkg::CFG_MAX_SPEED_Y:
                        max_y_reg <= (cfg_wdata == '0) ? xymq_pkg::MAXSP_W'(1) : cfg_wdata;
                endcase
            end

            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= (s_axis_tuser[0] == xymq_pkg::ACT_SERVICE) ?
                                     S_SVC : S_PLAN;
                end
                S_PLAN:
                begin
                    if (zero_move)
                        state_reg <= S_COMMIT;
                    else if ((dx_reg == '0) || (dy_reg == '0))
                        state_reg <= S_TX_DIV;
                    else
                        state_reg <= S_VX_DIV;
                end
                S_VX_DIV:  state_reg <= S_VX_WAIT;
                S_VX_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= (div_q > DW'(mx)) ? S_VY_MUL : S_TX_DIV;
                end
                S_VY_MUL:  state_reg <= S_VY_DIV;
                S_VY_DIV:  state_reg <= S_VY_WAIT;
                S_VY_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= S_TX_DIV;
                end
                S_TX_DIV:  state_reg <= div_start ? S_TX_WAIT : S_TY_DIV;
                S_TX_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= S_TY_DIV;
                end
                S_TY_DIV:  state_reg <= div_start ? S_TY_WAIT : S_COMMIT;
                S_TY_WAIT:
                begin
                    if (div_stat.done)
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (!queue_full)
                    begin
                        tail_reg   <= tail_inc;
                        count_reg  <= count_reg + 1'b1;
                        total_reg  <= total_reg + TOT_W'(plan_time);
                        last_x_reg <= tgt_x_reg;
                        last_y_reg <= tgt_y_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_SVC:
                begin
                    if (dispatch)
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                        total_reg <= total_reg - TOT_W'(rd_t);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tgt_x_reg <= in_x;
                    tgt_y_reg <= in_y;
                    dwell_reg <= in_dwell;
                    idle_reg  <= in_idle;
                    dx_reg    <= (in_x > last_x_reg) ? in_x - last_x_reg : last_x_reg - in_x;
                    dy_reg    <= (in_y > last_y_reg) ? in_y - last_y_reg : last_y_reg - in_y;
                end
            end
            S_PLAN:
            begin
                prod_reg <= mul_p;
                vx_reg   <= (dy_reg == '0) ? mx : '0;
                vy_reg   <= my;
                tx_t_reg <= '0;
                ty_t_reg <= '0;
            end
            S_VX_WAIT:
            begin
                if (div_stat.done)
                    vx_reg <= (div_q > DW'(mx)) ? mx : div_q[SPD_W-1:0];
            end
            S_VY_MUL:
            begin
                prod_reg <= mul_p;
            end
            S_VY_WAIT:
            begin
                if (div_stat.done)
                    vy_reg <= q_sat24;
            end
            S_TX_DIV:
            begin
                // moving axis whose speed truncated to zero
                if ((dx_reg != '0) && (vx_reg == '0))
                    tx_t_reg <= '1;
            end
            S_TX_WAIT:
            begin
                if (div_stat.done)
                    tx_t_reg <= q_sat32;
            end
            S_TY_DIV:
            begin
                if ((dy_reg != '0) && (vy_reg == '0))
                    ty_t_reg <= '1;
            end
            S_TY_WAIT:
            begin
                if (div_stat.done)
                    ty_t_reg <= q_sat32;
            end
            S_COMMIT:
            begin
                res_xs_reg   <= zero_move ? '0 : vx_reg;
                res_ys_reg   <= zero_move ? '0 : vy_reg;
                res_mt_reg   <= plan_time;
                res_dv_reg   <= 1'b0;
                res_dx_reg   <= '0;
                res_dy_reg   <= '0;
                res_drop_reg <= queue_full;
            end
            S_SVC:
            begin
                res_xs_reg   <= '0;
                res_ys_reg   <= '0;
                res_mt_reg   <= dispatch ? rd_t : '0;
                res_dv_reg   <= dispatch;
                res_dx_reg   <= dispatch ? rd_x : '0;
                res_dy_reg   <= dispatch ? rd_y : '0;
                res_drop_reg <= 1'b0;
            end
            S_OUT:
            begin
                if (out_free)
                    out_data_reg <= out_pack;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    always_comb
    begin
        out_pack = xymq_pkg::M_TDATA_W'({
            res_drop_reg,
            res_dy_reg,
            res_dx_reg,
            res_dv_reg,
            xymq_pkg::QLEN_W'(count_reg),
            total_reg,
            res_mt_reg,
            res_ys_reg,
            res_xs_reg
        });
    end

    // move store
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_COMMIT) && !queue_full)
            mem[tail_reg] <= {plan_time, tgt_y_reg, tgt_x_reg};
        rd_data_reg <= mem[head_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_COMMIT) && !queue_full) |=>
        (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("stored move not counted");

endmodule

// File: rtl/xymq_div.sv
module xymq_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [xymq_pkg::DIV_DW-1:0]   dividend,
    input  logic [xymq_pkg::DIV_VW-1:0]   divisor,
    output xymq_pkg::div_stat_t           stat,
    output logic [xymq_pkg::DIV_DW-1:0]   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [xymq_pkg::DIV_CW-1:0]   cnt_reg;
    logic [xymq_pkg::DIV_DW-1:0]   quo_reg;
    logic [xymq_pkg::DIV_VW-1:0]   rem_reg;
    logic [xymq_pkg::DIV_VW-1:0]   dvs_reg;

    logic [xymq_pkg::DIV_VW:0]     trial;
    logic [xymq_pkg::DIV_VW:0]     diff;
    logic                          ge;

    assign trial = {rem_reg, quo_reg[xymq_pkg::DIV_DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= xymq_pkg::DIV_CW'(xymq_pkg::DIV_DW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // restoring, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[xymq_pkg::DIV_DW-2:0], ge};
            rem_reg <= ge ? diff[xymq_pkg::DIV_VW-1:0] : trial[xymq_pkg::DIV_VW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
